// ===== src/assert_macros.svh =====
// Assertion macros shared by the image_neighbour_contrast RTL.
// Depends on nothing; expects clk_i and rst_ni in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clk_i edge, off while rst_ni is low.
`define INC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: assertion failed");

// Checks that a condition implies another in the same cycle.
`define INC_ASSERT_IMPLY(lbl, cond, conseq) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (conseq)) \
    else $error("%m: implication failed");

`endif

// ===== src/inc_pkg.sv =====
// Package for image_neighbour_contrast: field widths, register indexes,
// queue sizing and the back-end state type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package inc_pkg;

  localparam int PIXEL_W     = 8;
  localparam int WIDTH_W     = 12;
  localparam int HEIGHT_W    = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int SUM_W       = 46;
  localparam int CONTRAST_W  = 24;
  localparam int FRAC_BITS   = 8;
  localparam int SQUARE_W    = 2 * PIXEL_W;

  localparam int DEFAULT_MAX_WIDTH = 2048;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

  // frame totals waiting between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic               empty;
    logic [LEVEL_W-1:0] level;
  } qstat_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_PROD,
    B_DENOM,
    B_DIV,
    B_DONE
  } back_state_e;

endpackage

`default_nettype wire

// ===== src/inc_front.sv =====
// Front end: pixel counters, one-row line buffer, squared differences and
// the frame accumulator. Uses inc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module inc_front #(
  parameter int MAX_WIDTH = inc_pkg::DEFAULT_MAX_WIDTH,
  parameter int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  parameter int WW = $clog2(MAX_WIDTH + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          restart_i,
  input  wire logic [WW-1:0]                 w_eff_i,
  input  wire logic [inc_pkg::HEIGHT_W-1:0]  h_eff_i,
  input  wire logic                          push_i,
  input  wire logic [inc_pkg::PIXEL_W-1:0]   pixel_i,
  output logic                               full_o,
  input  wire inc_pkg::qstat_t               qstat_i,
  output logic                               q_push_o,
  output logic [inc_pkg::SUM_W-1:0]          q_sum_o
);
  import inc_pkg::*;

  logic [PIXEL_W-1:0] row_mem [MAX_WIDTH];

  logic [CW-1:0]       col_q;
  logic [HEIGHT_W-1:0] row_q;
  logic [PIXEL_W-1:0]  left_q;

  logic                s1_valid_q, s1_use_left_q, s1_use_up_q, s1_last_q;
  logic [PIXEL_W-1:0]  s1_pix_q, s1_left_q, s1_above_q;

  logic                s2_valid_q, s2_last_q;
  logic [SQUARE_W-1:0] s2_sql_q, s2_squ_q;

  logic [SUM_W-1:0]    sum_q;

  logic                accept, last_col, last_row;
  logic [PIXEL_W-1:0]  d_left, d_up;
  logic [SUM_W-1:0]    total;
  logic [LEVEL_W:0]    pending;

  // one frame total per last pixel in flight must still find room
  assign pending  = {1'b0, qstat_i.level} + (LEVEL_W+1)'(s1_valid_q & s1_last_q)
                    + (LEVEL_W+1)'(s2_valid_q & s2_last_q);
  assign full_o   = pending >= (LEVEL_W+1)'(QUEUE_DEPTH);
  assign accept   = push_i & ~full_o;
  assign last_col = WW'(col_q) == (w_eff_i - WW'(1));
  assign last_row = row_q == (h_eff_i - HEIGHT_W'(1));

  // line buffer: read old value and write the new one at the same column
  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_mem[col_q] <= pixel_i;
      s1_above_q     <= row_mem[col_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      left_q     <= '0;
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
    end else if (restart_i) begin
      col_q      <= '0;
      row_q      <= '0;
      left_q     <= '0;
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      if (accept) begin
        left_q    <= pixel_i;
        s1_last_q <= last_col & last_row;
        if (last_col) begin
          col_q <= '0;
          row_q <= last_row ? '0 : row_q + HEIGHT_W'(1);
        end else begin
          col_q <= col_q + CW'(1);
        end
      end else begin
        s1_last_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q      <= pixel_i;
      s1_left_q     <= left_q;
      s1_use_left_q <= col_q != '0;
      s1_use_up_q   <= row_q != '0;
    end
  end

  assign d_left = (s1_pix_q > s1_left_q)  ? s1_pix_q - s1_left_q  : s1_left_q - s1_pix_q;
  assign d_up   = (s1_pix_q > s1_above_q) ? s1_pix_q - s1_above_q : s1_above_q - s1_pix_q;

  always_ff @(posedge clk_i) begin
    s2_sql_q <= s1_use_left_q ? d_left * d_left : '0;
    s2_squ_q <= s1_use_up_q   ? d_up * d_up     : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s2_last_q  <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q & ~restart_i;
      s2_last_q  <= s1_valid_q & s1_last_q & ~restart_i;
    end
  end

  // each pair counts twice, once from either side
  assign total = sum_q + SUM_W'({SUM_W'(s2_sql_q) + SUM_W'(s2_squ_q), 1'b0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (restart_i) begin
      sum_q <= '0;
    end else if (s2_valid_q) begin
      sum_q <= s2_last_q ? '0 : total;
    end
  end

  assign q_push_o = s2_valid_q & s2_last_q;
  assign q_sum_o  = total;

  `INC_ASSERT_IMPLY(a_push_room, q_push_o, qstat_i.level != LEVEL_W'(QUEUE_DEPTH))
  `INC_ASSERT(a_one_last_in_flight, !(s1_valid_q && s1_last_q && s2_valid_q && s2_last_q))

endmodule

`default_nettype wire

// ===== src/inc_queue.sv =====
// Short queue of finished frame totals between front and back end.
// Uses inc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module inc_queue (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      push_i,
  input  wire logic [inc_pkg::SUM_W-1:0] data_i,
  input  wire logic                      pop_i,
  output logic [inc_pkg::SUM_W-1:0]      data_o,
  output inc_pkg::qstat_t                stat_o
);
  import inc_pkg::*;

  logic [SUM_W-1:0]   slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_q, rd_q;
  logic [LEVEL_W-1:0] level_q;

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      level_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
      if (pop_i)  rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
      case ({push_i, pop_i})
        2'b10:   level_q <= level_q + LEVEL_W'(1);
        2'b01:   level_q <= level_q - LEVEL_W'(1);
        default: level_q <= level_q;
      endcase
    end
  end

  assign data_o       = slot_q[rd_q];
  assign stat_o.empty = level_q == '0;
  assign stat_o.level = level_q;

  `INC_ASSERT(a_level_bound, level_q <= LEVEL_W'(QUEUE_DEPTH))
  `INC_ASSERT_IMPLY(a_no_pop_empty, pop_i, level_q != '0)

endmodule

`default_nettype wire

// ===== src/inc_back.sv =====
// Back end: pair count from the frame size, bit-serial division of the
// frame total and the result register. Uses inc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module inc_back #(
  parameter int WW = 12
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [WW-1:0]                  w_eff_i,
  input  wire logic [inc_pkg::HEIGHT_W-1:0]   h_eff_i,
  input  wire inc_pkg::qstat_t                qstat_i,
  input  wire logic [inc_pkg::SUM_W-1:0]      q_sum_i,
  output logic                                q_pop_o,
  input  wire logic                           pop_i,
  output logic                                empty_o,
  output logic [inc_pkg::CONTRAST_W-1:0]      contrast_q8_o,
  output logic [inc_pkg::SUM_W-1:0]           square_sum_o
);
  import inc_pkg::*;

  localparam int PW        = WW + HEIGHT_W;
  localparam int DW        = PW + 2;
  localparam int DVD_W     = SUM_W + FRAC_BITS;
  localparam int DIV_STEPS = DVD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  back_state_e state_q, state_d;

  logic [PW-1:0]         prod_q;
  logic [DW-1:0]         denom_q;
  logic [DW:0]           rem_q;
  logic [DVD_W-1:0]      dvd_q;
  logic [CONTRAST_W-1:0] quo_q;
  logic [SUM_W-1:0]      sum_hold_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  out_valid_q;

  logic        load_out;
  logic [DW:0] rem_sh, rem_nx;
  logic        ge;

  assign rem_sh = {rem_q[DW-1:0], dvd_q[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, denom_q};
  assign rem_nx = ge ? rem_sh - {1'b0, denom_q} : rem_sh;

  always_comb begin
    state_d  = state_q;
    q_pop_o  = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (!qstat_i.empty) begin
          q_pop_o = 1'b1;
          state_d = B_PROD;
        end
      end
      B_PROD:  state_d = B_DENOM;
      B_DENOM: state_d = B_DIV;
      B_DIV: begin
        if (cnt_q == '0) state_d = B_DONE;
      end
      B_DONE: begin
        if (!out_valid_q || pop_i) begin
          load_out = 1'b1;
          state_d  = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_DENOM)    cnt_q <= CNT_W'(DIV_STEPS - 1);
      else if (state_q == B_DIV) cnt_q <= cnt_q - CNT_W'(1);
      if (load_out)   out_valid_q <= 1'b1;
      else if (pop_i) out_valid_q <= 1'b0;
    end
  end

  // datapath; denominator is 4HW - 2H - 2W
  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        sum_hold_q <= q_sum_i;
        dvd_q      <= {q_sum_i, FRAC_BITS'(0)};
        rem_q      <= '0;
        quo_q      <= '0;
      end
      B_PROD: prod_q <= w_eff_i * h_eff_i;
      B_DENOM: begin
        denom_q <= {prod_q, 2'b00} - DW'({h_eff_i, 1'b0}) - DW'({w_eff_i, 1'b0});
      end
      B_DIV: begin
        rem_q <= rem_nx;
        dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
        quo_q <= {quo_q[CONTRAST_W-2:0], ge};
      end
      default: ;
    endcase
    if (load_out) begin
      contrast_q8_o <= quo_q;
      square_sum_o  <= sum_hold_q;
    end
  end

  assign empty_o = ~out_valid_q;

  `INC_ASSERT(a_div_flow,
              (state_q == B_DIV) |=> (state_q == B_DIV || state_q == B_DONE))
  `INC_ASSERT_IMPLY(a_rem_below_denom, state_q == B_DIV, rem_q < {1'b0, denom_q})

endmodule

`default_nettype wire

// ===== src/image_neighbour_contrast.sv =====
// Top level of image_neighbour_contrast: configuration registers, frame
// size clamping and the front / queue / back chain. Uses inc_pkg and the
// inc_front, inc_queue and inc_back modules.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+-------------------------
//  pixel    | in        | push / full                | pixel_i
//  result   | out       | pop / empty                | contrast_q8_o, square_sum_o
//  config   | in        | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// Pixels are taken one per cycle while full is low; the front end is a
// three-stage pipe (line buffer read, squaring, accumulate) and never
// stalls by itself. After the last pixel of a frame its total enters a
// two-entry queue; the back end takes one frame at a time: the pair count,
// the one-bit-a-cycle restoring division, then load and handoff.
// full rises only while the queue plus frame ends in flight fill it.
// Reset restores 640 x 480 and an empty pipe; the line buffer is not
// cleared, its value is only used at columns already written in the frame.
`timescale 1ns / 1ps
`default_nettype none

module image_neighbour_contrast #(
  parameter int MAX_WIDTH = inc_pkg::DEFAULT_MAX_WIDTH
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // pixel input
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [inc_pkg::PIXEL_W-1:0]     pixel_i,
  // results
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [inc_pkg::CONTRAST_W-1:0]       contrast_q8_o,
  output logic [inc_pkg::SUM_W-1:0]            square_sum_o,
  // configuration writes
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [inc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [inc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import inc_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [WW-1:0]       w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic                restart;

  logic             q_push, q_pop;
  logic [SUM_W-1:0] q_in, q_out;
  qstat_t           qstat;

  // config port never stalls; a write to a known register drops the frame
  assign cfg_ready_o = 1'b1;
  assign restart     = cfg_valid_i &
                       (cfg_index_i == CFG_FRAME_WIDTH || cfg_index_i == CFG_FRAME_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_FRAME_WIDTH)  width_q  <= cfg_data_i[WIDTH_W-1:0];
      if (cfg_index_i == CFG_FRAME_HEIGHT) height_q <= cfg_data_i[HEIGHT_W-1:0];
    end
  end

  // width clamps to [2, MAX_WIDTH], height to at least 2
  always_comb begin
    if (32'(width_q) > 32'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else if (width_q < WIDTH_W'(2))    w_eff = WW'(2);
    else                               w_eff = WW'(width_q);
    h_eff = (height_q < HEIGHT_W'(2)) ? HEIGHT_W'(2) : height_q;
  end

  inc_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW),
    .WW        (WW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (restart),
    .w_eff_i   (w_eff),
    .h_eff_i   (h_eff),
    .push_i    (push),
    .pixel_i   (pixel_i),
    .full_o    (full),
    .qstat_i   (qstat),
    .q_push_o  (q_push),
    .q_sum_o   (q_in)
  );

  inc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_in),
    .pop_i  (q_pop),
    .data_o (q_out),
    .stat_o (qstat)
  );

  inc_back #(
    .WW (WW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .w_eff_i       (w_eff),
    .h_eff_i       (h_eff),
    .qstat_i       (qstat),
    .q_sum_i       (q_out),
    .q_pop_o       (q_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .contrast_q8_o (contrast_q8_o),
    .square_sum_o  (square_sum_o)
  );

endmodule

`default_nettype wire
